@@ sv/dtq_pkg.sv @@
// deadline timer queue: shared constants, codes and controller/datapath types
// no dependencies
`default_nettype none

package dtq_pkg;

   localparam int NUM_TIMERS  = 8;
   localparam int ID_W        = 3;
   localparam int CNT_W       = 4;
   localparam int MAX_RESULTS = 8;
   localparam int DL_W        = 64;
   localparam int IV_W        = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL = 2'd1;

   localparam logic [IV_W-1:0] MIN_INTERVAL_RESET = 32'd50;
   localparam logic [IV_W-1:0] MAX_INTERVAL_RESET = 32'd1000000;

   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic load_req;
      logic remove;
      logic scan_clr;
      logic scan_step;
      logic insert;
      logic tick_now;
      logic expire_head;
      logic wake_diff;
      logic wake_clamp;
      logic emit_clr;
      logic emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_hit;
      logic   head_due;
      logic   emit_last;
      logic   rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

@@ sv/dtq_dpath.sv @@
// deadline timer queue datapath: sorted list, slot state, time, wake clamp, result register
// depends on dtq_pkg
`default_nettype none

module dtq_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [dtq_pkg::ID_W-1:0]       req_timer_id,
   input  wire logic [dtq_pkg::DL_W-1:0]       req_deadline,
   input  wire logic                           csr_valid,
   input  wire logic [dtq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dtq_pkg::IV_W-1:0]       csr_data,
   input  wire dtq_pkg::cmd_type               cmd,
   output dtq_pkg::stat_type                   stat,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_expired_valid,
   output logic [dtq_pkg::ID_W-1:0]            rsp_expired_id,
   output logic                                rsp_last,
   output logic                                rsp_head_valid,
   output logic [dtq_pkg::IV_W-1:0]            rsp_wake_interval
);

   localparam int N = dtq_pkg::NUM_TIMERS;

   logic [1:0]                  op_ff, op_in;
   logic [dtq_pkg::ID_W-1:0]    id_ff, id_in;
   logic [dtq_pkg::DL_W-1:0]    dl_ff, dl_in;
   logic [dtq_pkg::DL_W-1:0]    now_ff, now_in;
   logic [dtq_pkg::ID_W-1:0]    pos_id_ff [N];
   logic [dtq_pkg::ID_W-1:0]    pos_id_in [N];
   logic [dtq_pkg::DL_W-1:0]    pos_dl_ff [N];
   logic [dtq_pkg::DL_W-1:0]    pos_dl_in [N];
   logic [N-1:0]                pend_ff, pend_in;
   logic [dtq_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [dtq_pkg::CNT_W-1:0]   ptr_ff, ptr_in;
   logic [dtq_pkg::ID_W-1:0]    exp_id_ff [dtq_pkg::MAX_RESULTS];
   logic [dtq_pkg::ID_W-1:0]    exp_id_in [dtq_pkg::MAX_RESULTS];
   logic [dtq_pkg::CNT_W-1:0]   nexp_ff, nexp_in;
   logic [dtq_pkg::CNT_W-1:0]   k_ff, k_in;
   logic [dtq_pkg::DL_W-1:0]    diff_ff, diff_in;
   logic                        dlt_ff, dlt_in;
   logic [dtq_pkg::IV_W-1:0]    wake_ff, wake_in;
   logic [dtq_pkg::IV_W-1:0]    min_ff, min_in;
   logic [dtq_pkg::IV_W-1:0]    max_ff, max_in;
   logic                        rv_ff, rv_in;
   logic                        rev_ff, rev_in;
   logic [dtq_pkg::ID_W-1:0]    rid_ff, rid_in;
   logic                        rlast_ff, rlast_in;
   logic                        rhv_ff, rhv_in;
   logic [dtq_pkg::IV_W-1:0]    rwake_ff, rwake_in;

   logic [N-1:0] after;
   logic         last_now;

   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < N; i++) begin
         seen = seen | ((dtq_pkg::CNT_W'(i) < cnt_ff) && (pos_id_ff[i] == id_ff));
         after[i] = seen;
      end
   end

   assign last_now = (nexp_ff == '0) || ((k_ff + 1'b1) == nexp_ff);

   always_comb begin
      stat.op        = dtq_pkg::op_type'(op_ff);
      stat.scan_hit  = (ptr_ff >= cnt_ff) || (dl_ff < pos_dl_ff[ptr_ff[dtq_pkg::ID_W-1:0]]);
      stat.head_due  = (cnt_ff != '0) && !(pos_dl_ff[0] > now_ff)
                       && (nexp_ff < dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS));
      stat.emit_last = last_now;
      stat.rsp_busy  = rv_ff && rsp_stall;
   end

   always_comb begin
      op_in     = op_ff;
      id_in     = id_ff;
      dl_in     = dl_ff;
      now_in    = now_ff;
      pos_id_in = pos_id_ff;
      pos_dl_in = pos_dl_ff;
      pend_in   = pend_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      exp_id_in = exp_id_ff;
      nexp_in   = nexp_ff;
      k_in      = k_ff;
      diff_in   = diff_ff;
      dlt_in    = dlt_ff;
      wake_in   = wake_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      rv_in     = rv_ff;
      rev_in    = rev_ff;
      rid_in    = rid_ff;
      rlast_in  = rlast_ff;
      rhv_in    = rhv_ff;
      rwake_in  = rwake_ff;

      if (cmd.load_req) begin
         op_in   = req_operation;
         id_in   = req_timer_id;
         dl_in   = req_deadline;
         nexp_in = '0;
      end

      if (cmd.remove && pend_ff[id_ff]) begin
         for (int i = 0; i < N - 1; i++) begin
            if (after[i]) begin
               pos_id_in[i] = pos_id_ff[i+1];
               pos_dl_in[i] = pos_dl_ff[i+1];
            end
         end
         cnt_in = cnt_ff - 1'b1;
         pend_in[id_ff] = 1'b0;
      end

      if (cmd.scan_clr) begin
         ptr_in = '0;
      end
      if (cmd.scan_step) begin
         ptr_in = ptr_ff + 1'b1;
      end

      if (cmd.insert && (cnt_ff < dtq_pkg::CNT_W'(N))) begin
         for (int i = 1; i < N; i++) begin
            if (dtq_pkg::CNT_W'(i) > ptr_ff) begin
               pos_id_in[i] = pos_id_ff[i-1];
               pos_dl_in[i] = pos_dl_ff[i-1];
            end
         end
         pos_id_in[ptr_ff[dtq_pkg::ID_W-1:0]] = id_ff;
         pos_dl_in[ptr_ff[dtq_pkg::ID_W-1:0]] = dl_ff;
         cnt_in = cnt_ff + 1'b1;
         pend_in[id_ff] = 1'b1;
      end

      if (cmd.tick_now) begin
         now_in = now_ff + 1'b1;
      end

      if (cmd.expire_head) begin
         exp_id_in[nexp_ff[dtq_pkg::ID_W-1:0]] = pos_id_ff[0];
         for (int i = 0; i < N - 1; i++) begin
            pos_id_in[i] = pos_id_ff[i+1];
            pos_dl_in[i] = pos_dl_ff[i+1];
         end
         pend_in[pos_id_ff[0]] = 1'b0;
         cnt_in  = cnt_ff - 1'b1;
         nexp_in = nexp_ff + 1'b1;
      end

      if (cmd.wake_diff) begin
         diff_in = pos_dl_ff[0] - now_ff;
         dlt_in  = pos_dl_ff[0] < now_ff;
      end

      if (cmd.wake_clamp) begin
         priority if (cnt_ff == '0) begin
            wake_in = '0;
         end else if (dlt_ff || (diff_ff < {32'd0, min_ff})) begin
            wake_in = min_ff;
         end else if (diff_ff > {32'd0, max_ff}) begin
            wake_in = max_ff;
         end else begin
            wake_in = diff_ff[dtq_pkg::IV_W-1:0];
         end
      end

      if (cmd.emit_clr) begin
         k_in = '0;
      end

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (cmd.emit) begin
         rv_in    = 1'b1;
         rev_in   = nexp_ff != '0;
         rid_in   = (nexp_ff != '0) ? exp_id_ff[k_ff[dtq_pkg::ID_W-1:0]] : '0;
         rlast_in = last_now;
         rhv_in   = cnt_ff != '0;
         rwake_in = wake_ff;
         k_in     = k_ff + 1'b1;
      end

      if (csr_valid) begin
         if (csr_index == dtq_pkg::CSR_MIN_INTERVAL) begin
            min_in = csr_data;
         end
         if (csr_index == dtq_pkg::CSR_MAX_INTERVAL) begin
            max_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff  <= '0;
         pend_ff <= '0;
         cnt_ff  <= '0;
         ptr_ff  <= '0;
         nexp_ff <= '0;
         k_ff    <= '0;
         min_ff  <= dtq_pkg::MIN_INTERVAL_RESET;
         max_ff  <= dtq_pkg::MAX_INTERVAL_RESET;
         rv_ff   <= 1'b0;
      end else begin
         now_ff  <= now_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         ptr_ff  <= ptr_in;
         nexp_ff <= nexp_in;
         k_ff    <= k_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      dl_ff     <= dl_in;
      pos_id_ff <= pos_id_in;
      pos_dl_ff <= pos_dl_in;
      exp_id_ff <= exp_id_in;
      diff_ff   <= diff_in;
      dlt_ff    <= dlt_in;
      wake_ff   <= wake_in;
      rev_ff    <= rev_in;
      rid_ff    <= rid_in;
      rlast_ff  <= rlast_in;
      rhv_ff    <= rhv_in;
      rwake_ff  <= rwake_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_expired_valid = rev_ff;
   assign rsp_expired_id    = rid_ff;
   assign rsp_last          = rlast_ff;
   assign rsp_head_valid    = rhv_ff;
   assign rsp_wake_interval = rwake_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= dtq_pkg::CNT_W'(N))
      else $error("pending count out of range");

   a_cnt_pend: assert property (@(posedge clock) disable iff (reset)
      $countones(pend_ff) == int'(cnt_ff))
      else $error("pending bits disagree with count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rv_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_expire_due: assert property (@(posedge clock) disable iff (reset)
      cmd.expire_head |-> (cnt_ff != '0) && !(pos_dl_ff[0] > now_ff))
      else $error("expired a slot that is not due");

endmodule

`default_nettype wire

@@ sv/dtq_ctrl.sv @@
// deadline timer queue controller: sequences remove, sorted insert scan, tick expiry,
// wake clamp and result transfers; depends on dtq_pkg
`default_nettype none

module dtq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dtq_pkg::stat_type stat,
   output dtq_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_REMOVE,
      S_SCAN,
      S_INSERT,
      S_TICK,
      S_EXPIRE,
      S_WAKE_DIFF,
      S_WAKE_CLAMP,
      S_EMIT
   } state_type;

   state_type state_ff;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_REMOVE: begin
            cmd.remove   = 1'b1;
            cmd.scan_clr = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_step = !stat.scan_hit;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
         end
         S_TICK: begin
            cmd.tick_now = 1'b1;
         end
         S_EXPIRE: begin
            cmd.expire_head = stat.head_due;
         end
         S_WAKE_DIFF: begin
            cmd.wake_diff = 1'b1;
         end
         S_WAKE_CLAMP: begin
            cmd.wake_clamp = 1'b1;
            cmd.emit_clr   = 1'b1;
         end
         S_EMIT: begin
            cmd.emit = !stat.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  unique case (stat.op)
                     dtq_pkg::OP_ARM,
                     dtq_pkg::OP_CANCEL: state_ff <= S_REMOVE;
                     dtq_pkg::OP_TICK:   state_ff <= S_TICK;
                     dtq_pkg::OP_NONE:   state_ff <= S_WAKE_DIFF;
                  endcase
               end
            end
            S_REMOVE: begin
               state_ff <= (stat.op == dtq_pkg::OP_ARM) ? S_SCAN : S_WAKE_DIFF;
            end
            S_SCAN: begin
               if (stat.scan_hit) begin
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               state_ff <= S_WAKE_DIFF;
            end
            S_TICK: begin
               state_ff <= S_EXPIRE;
            end
            S_EXPIRE: begin
               if (!stat.head_due) begin
                  state_ff <= S_WAKE_DIFF;
               end
            end
            S_WAKE_DIFF: begin
               state_ff <= S_WAKE_CLAMP;
            end
            S_WAKE_CLAMP: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!stat.rsp_busy && stat.emit_last) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_one_list_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.remove, cmd.insert, cmd.expire_head}))
      else $error("two list updates at once");

   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.emit_last) |=> (state_ff == S_IDLE))
      else $error("controller missed end of results");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> req_stall)
      else $error("second item taken while one is in flight");

endmodule

`default_nettype wire

@@ sv/deadline_timer_queue.sv @@
// deadline timer queue top level: controller plus datapath
// depends on dtq_pkg, dtq_ctrl, dtq_dpath
//
//  port group   direction  flow control        payload
//  req_         in         req_valid/req_stall operation, timer_id, deadline
//  rsp_         out        rsp_valid/rsp_stall expired_valid, expired_id, last, head_valid,
//                                              wake_interval
//  csr_         in         csr_valid/csr_ready index, data
//
// arm runs remove, a scan to the insert position (one deadline compare a cycle), insert,
// wake diff, wake clamp and emit; cancel runs remove and the wake and emit steps
// unused code runs the wake and emit steps; tick advances time, expires each due head, then
// the wake and emit steps (one result per expired timer, else one); stalls hold emit; idle
// takes the next item, while the last result may still wait in the output register
// synchronous active high reset clears time and pending bits, presets interval registers
`default_nettype none

module deadline_timer_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [dtq_pkg::ID_W-1:0]      req_timer_id,
   input  wire logic [dtq_pkg::DL_W-1:0]      req_deadline,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_expired_valid,
   output logic [dtq_pkg::ID_W-1:0]           rsp_expired_id,
   output logic                               rsp_last,
   output logic                               rsp_head_valid,
   output logic [dtq_pkg::IV_W-1:0]           rsp_wake_interval,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dtq_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dtq_pkg::IV_W-1:0]      csr_data
);

   dtq_pkg::cmd_type  cmd;
   dtq_pkg::stat_type stat;
   dtq_pkg::stat_type stat_ctl;

   assign csr_ready = 1'b1;

   always_comb begin
      stat_ctl    = stat;
      stat_ctl.op = req_stall ? stat.op : dtq_pkg::op_type'(req_operation);
   end

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat_ctl),
      .cmd       (cmd)
   );

   dtq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_deadline      (req_deadline),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_last          (rsp_last),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_wake_interval (rsp_wake_interval)
   );

endmodule

`default_nettype wire
